// File: rtl/kmp_pkg.sv
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int CH_BITS  = 8;
  localparam int OUT_BITS = 32;

  typedef enum logic [1:0] {
    CMD_NEW,
    CMD_APPEND,
    CMD_TEXT,
    CMD_SKIP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [CH_BITS-1:0] ch;
  } cmd_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK
  } eng_state_t;

endpackage

// File: rtl/kmp_ram.sv
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/kmp_queue.sv
`timescale 1ns / 1ps

module kmp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// File: rtl/kmp_front.sv
`timescale 1ns / 1ps

module kmp_front
  import kmp_pkg::*;
#(
  parameter int PAT_MAX = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               op,
  input  logic [CH_BITS-1:0] ch,
  input  logic               first,
  output logic               cmd_push,
  output cmd_item_t          cmd
);

  localparam int LEN_BITS = $clog2(PAT_MAX + 1);

  logic [LEN_BITS-1:0] held;
  logic [LEN_BITS-1:0] held_next;

  always_comb begin
    held_next = held;
    cmd_push  = 1'b0;
    cmd.ch    = ch;
    cmd.op    = CMD_SKIP;
    if (op) begin
      cmd_push = accept;
      cmd.op   = (held == '0) ? CMD_SKIP : CMD_TEXT;
    end else if (first) begin
      cmd_push = accept;
      cmd.op   = CMD_NEW;
      if (accept) begin
        held_next = LEN_BITS'(1);
      end
    end else if (held < LEN_BITS'(PAT_MAX)) begin
      cmd_push = accept;
      cmd.op   = CMD_APPEND;
      if (accept) begin
        held_next = held + LEN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= held_next;
    end
  end

endmodule

// File: rtl/kmp_engine.sv
`timescale 1ns / 1ps

module kmp_engine
  import kmp_pkg::*;
#(
  parameter int PAT_MAX  = 64,
  parameter int POS_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  cmd_item_t           cmd,
  output logic                cmd_pop,
  input  logic                out_full,
  output logic                out_push,
  output logic [OUT_BITS-1:0] out_position
);

  localparam int LEN_BITS = $clog2(PAT_MAX + 1);
  localparam int IDX_BITS = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

  eng_state_t          state;
  eng_state_t          state_next;
  logic [LEN_BITS-1:0] plen;
  logic [LEN_BITS-1:0] mlen;
  logic [POS_BITS-1:0] pos;
  logic [LEN_BITS-1:0] last_fail;
  logic [LEN_BITS-1:0] k;
  logic [CH_BITS-1:0]  c;
  logic                is_text;

  logic [CH_BITS-1:0]  pat_rd;
  logic [LEN_BITS-1:0] fail_rd;
  logic [IDX_BITS-1:0] pat_raddr;
  logic [IDX_BITS-1:0] fail_raddr;
  logic                pat_we;
  logic                fail_we;
  logic [IDX_BITS-1:0] waddr;
  logic [CH_BITS-1:0]  pat_wdata;
  logic [LEN_BITS-1:0] fail_wdata;

  logic                go;
  logic                hit;
  logic                finish;
  logic [LEN_BITS-1:0] kn;
  logic [LEN_BITS-1:0] k_start;
  logic [LEN_BITS-1:0] k_start_less;
  logic [LEN_BITS-1:0] fail_rd_less;
  logic [LEN_BITS-1:0] plen_less;
  logic [POS_BITS-1:0] start;

  assign go           = cmd_valid && (cmd.op != CMD_TEXT || !out_full);
  assign hit          = (pat_rd == c);
  assign finish       = hit || (k == '0);
  assign kn           = hit ? k + LEN_BITS'(1) : '0;
  assign k_start      = (mlen >= plen) ? '0 : mlen;
  assign k_start_less = k_start - LEN_BITS'(1);
  assign fail_rd_less = fail_rd - LEN_BITS'(1);
  assign plen_less    = plen - LEN_BITS'(1);
  assign start        = pos - POS_BITS'(plen) + POS_BITS'(1);
  assign out_position = OUT_BITS'(start);

  kmp_ram #(.WIDTH(CH_BITS), .DEPTH(PAT_MAX)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (waddr),
    .wdata (pat_wdata),
    .raddr (pat_raddr),
    .rdata (pat_rd)
  );

  kmp_ram #(.WIDTH(LEN_BITS), .DEPTH(PAT_MAX)) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (waddr),
    .wdata (fail_wdata),
    .raddr (fail_raddr),
    .rdata (fail_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go) begin
          if (cmd.op == CMD_TEXT) begin
            state_next = ST_WALK;
          end else if (cmd.op == CMD_APPEND && plen != '0) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: state_next = ST_WALK;
      ST_WALK: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    out_push   = 1'b0;
    pat_we     = 1'b0;
    fail_we    = 1'b0;
    waddr      = '0;
    pat_wdata  = c;
    fail_wdata = kn;
    pat_raddr  = fail_rd[IDX_BITS-1:0];
    fail_raddr = fail_rd_less[IDX_BITS-1:0];
    unique case (state)
      ST_IDLE: begin
        cmd_pop    = go;
        pat_raddr  = k_start[IDX_BITS-1:0];
        fail_raddr = (cmd.op == CMD_TEXT) ? k_start_less[IDX_BITS-1:0]
                                          : plen_less[IDX_BITS-1:0];
        pat_wdata  = cmd.ch;
        fail_wdata = '0;
        if (go && (cmd.op == CMD_NEW || (cmd.op == CMD_APPEND && plen == '0))) begin
          pat_we  = 1'b1;
          fail_we = 1'b1;
        end
      end
      ST_LOAD: begin
      end
      ST_WALK: begin
        if (finish) begin
          if (is_text) begin
            out_push = (kn == plen);
          end else begin
            pat_we  = 1'b1;
            fail_we = 1'b1;
            waddr   = plen[IDX_BITS-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      plen      <= '0;
      mlen      <= '0;
      pos       <= '0;
      last_fail <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (go) begin
            unique case (cmd.op)
              CMD_NEW: begin
                plen      <= LEN_BITS'(1);
                mlen      <= '0;
                pos       <= '0;
                last_fail <= '0;
              end
              CMD_APPEND: begin
                if (plen == '0) begin
                  plen      <= LEN_BITS'(1);
                  last_fail <= '0;
                end
              end
              CMD_SKIP: pos <= pos + POS_BITS'(1);
              CMD_TEXT: begin
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOAD: begin
        end
        ST_WALK: begin
          if (finish) begin
            if (is_text) begin
              mlen <= (kn == plen) ? last_fail : kn;
              pos  <= pos + POS_BITS'(1);
            end else begin
              plen      <= plen + LEN_BITS'(1);
              last_fail <= kn;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      c       <= cmd.ch;
      is_text <= (cmd.op == CMD_TEXT);
      k       <= k_start;
    end else if (state == ST_LOAD || !finish) begin
      k <= fail_rd;
    end
  end

endmodule

// File: rtl/kmp_pattern_matcher.sv
`timescale 1ns / 1ps
// channel   direction  handshake          fields
// input     in         push / full        op, ch, first
// result    out        pop / empty        position
//
// a pattern beat with first set, or the first beat of an empty pattern, is written while
// idle; any other pattern beat passes through load and then walks the failure links
// a text beat walks the failure links (with an empty pattern it is only counted); steps are
// amortised to at most one per text beat
// rst is synchronous; the memories are not cleared, only entries below the length are read
// two-entry command and result queues decouple the sides; text waits for result room

module kmp_pattern_matcher
  import kmp_pkg::*;
#(
  parameter int PAT_MAX  = 64,
  parameter int POS_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                op,
  input  logic [CH_BITS-1:0]  ch,
  input  logic                first,
  output logic                empty,
  input  logic                pop,
  output logic [OUT_BITS-1:0] position
);

  logic                accept;
  logic                cmd_push;
  cmd_item_t           cmd_in;
  logic                cmd_empty;
  logic                cmd_pop;
  logic [$bits(cmd_item_t)-1:0] cmd_bits;
  logic                out_full;
  logic                out_push;
  logic [OUT_BITS-1:0] out_position;

  assign accept = push && !full;

  kmp_front #(.PAT_MAX(PAT_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (op),
    .ch       (ch),
    .first    (first),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  kmp_queue #(.WIDTH($bits(cmd_item_t)), .DEPTH(2)) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_bits)
  );

  kmp_engine #(.PAT_MAX(PAT_MAX), .POS_BITS(POS_BITS)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!cmd_empty),
    .cmd          (cmd_item_t'(cmd_bits)),
    .cmd_pop      (cmd_pop),
    .out_full     (out_full),
    .out_push     (out_push),
    .out_position (out_position)
  );

  kmp_queue #(.WIDTH(OUT_BITS), .DEPTH(2)) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .full  (out_full),
    .wdata (out_position),
    .pop   (pop),
    .empty (empty),
    .rdata (position)
  );

endmodule

// File: bench/tb_kmp_pattern_matcher.sv
`timescale 1ns / 1ps

module tb_kmp_pattern_matcher
  import kmp_pkg::*;
;

  localparam int   PAT_MAX        = 64;
  localparam logic OP_PATTERN     = 1'b0;
  localparam logic OP_TEXT        = 1'b1;
  localparam int   N_DIRECTED     = 23;
  localparam int   N_RANDOM       = 600;
  localparam int   STALL_CYCLES   = 400;
  localparam int   TAIL_CYCLES    = 150;
  localparam int   WATCHDOG_LIMIT = 5000;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_AT
  } start_check_t;

  typedef struct packed {
    logic                op;
    logic [CH_BITS-1:0]  ch;
    logic                first;
    start_check_t        chk;
    logic [OUT_BITS-1:0] at;
  } stim_row_t;

  typedef struct packed {
    start_check_t        chk;
    logic [OUT_BITS-1:0] at;
  } beat_check_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                push;
  logic                full;
  logic                op;
  logic [CH_BITS-1:0]  ch;
  logic                first;
  logic                empty;
  logic                pop;
  logic [OUT_BITS-1:0] position;

  kmp_pattern_matcher u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .op       (op),
    .ch       (ch),
    .first    (first),
    .empty    (empty),
    .pop      (pop),
    .position (position)
  );

  always #10 clk = ~clk;

  // matcher state as seen by the bench
  logic [CH_BITS-1:0]  pat_mem [PAT_MAX];
  logic [6:0]          fail_mem [PAT_MAX];
  int unsigned         pat_len = 0;
  int unsigned         match_len = 0;
  logic [OUT_BITS-1:0] text_pos = '0;

  beat_check_t         beat_checks [$];
  logic [OUT_BITS-1:0] pending_starts [$];

  int err_cnt = 0;
  int beats_in = 0;
  int starts_out = 0;
  int dropped = 0;
  int longest = 0;
  int tx_idle_pct = 29;
  int rx_idle_pct = 66;
  int idle_cycles = 0;
  bit stall_req = 1'b0;

  function automatic int unsigned extend_match(int unsigned k, logic [CH_BITS-1:0] c);
    while (k > 0 && pat_mem[k] != c) k = fail_mem[k-1];
    if (pat_mem[k] == c) k++;
    return k;
  endfunction

  task automatic step_matcher(input logic o, input logic [CH_BITS-1:0] c, input logic f,
                              output bit hit, output logic [OUT_BITS-1:0] start);
    int unsigned k;
    hit = 1'b0;
    start = '0;
    if (o == OP_PATTERN) begin
      if (f) begin
        pat_len = 0;
        match_len = 0;
        text_pos = '0;
      end
      if (pat_len >= PAT_MAX) begin
        dropped++;
        return;
      end
      pat_mem[pat_len] = c;
      fail_mem[pat_len] = (pat_len == 0) ? 7'd0 : 7'(extend_match(fail_mem[pat_len-1], c));
      pat_len++;
      if (pat_len > longest) longest = pat_len;
    end else begin
      if (pat_len > 0) begin
        k = (match_len >= pat_len) ? 0 : match_len;
        k = extend_match(k, c);
        if (k == pat_len) begin
          hit = 1'b1;
          start = text_pos - OUT_BITS'(pat_len) + 1;
          k = fail_mem[pat_len-1];
        end
        match_len = k;
      end
      text_pos++;
    end
  endtask

  // result check first, so a beat accepted on the same edge cannot mask a stray result
  always @(posedge clk) begin
    beat_check_t         bc;
    bit                  hit;
    logic [OUT_BITS-1:0] st;
    logic [OUT_BITS-1:0] want;
    if (!rst && pop && !empty) begin
      starts_out++;
      if (pending_starts.size() == 0) begin
        err_cnt++;
        $error("position: expected none, got %0d", position);
      end else begin
        want = pending_starts.pop_front();
        if (position !== want) begin
          err_cnt++;
          $error("position: expected %0d, got %0d", want, position);
        end
      end
    end
    if (!rst && push && !full) begin
      bc = beat_checks.pop_front();
      step_matcher(op, ch, first, hit, st);
      beats_in++;
      case (bc.chk)
        CHK_AT: pending_starts = {pending_starts, bc.at};
        CHK_MODEL: if (hit) pending_starts = {pending_starts, st};
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[kmp_pattern_matcher] ERROR");
      $finish;
    end
  end

  initial begin
    pop = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        pop <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic offer_beat(input logic o, input logic [CH_BITS-1:0] c, input logic f,
                            input start_check_t k, input logic [OUT_BITS-1:0] at);
    beat_check_t bc;
    bc.chk = k;
    bc.at = at;
    beat_checks = {beat_checks, bc};
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= o;
    ch <= c;
    first <= f;
    do @(posedge clk); while (full);
  endtask

  initial begin
    stim_row_t          dir_rows [N_DIRECTED];
    logic [CH_BITS-1:0] syms [3];
    logic [CH_BITS-1:0] base;
    int                 nsym;
    int                 plen;
    int                 tlen;
    int                 rand_beats;
    bit                 long_seg;
    bit                 stall_done;
    rst = 1'b1;
    push = 1'b0;
    op = 1'b0;
    ch = '0;
    first = 1'b0;
    rand_beats = 0;
    stall_done = 1'b0;
    dir_rows = '{
      '{OP_TEXT,    8'h61, 1'b0, CHK_NONE,  32'd0},
      '{OP_TEXT,    8'h61, 1'b1, CHK_NONE,  32'd0},
      '{OP_PATTERN, 8'h61, 1'b1, CHK_NONE,  32'd0},
      '{OP_TEXT,    8'h61, 1'b0, CHK_AT,    32'd0},
      '{OP_TEXT,    8'h61, 1'b0, CHK_AT,    32'd1},
      '{OP_TEXT,    8'h62, 1'b0, CHK_NONE,  32'd0},
      '{OP_PATTERN, 8'h62, 1'b0, CHK_NONE,  32'd0},
      '{OP_TEXT,    8'h61, 1'b0, CHK_MODEL, 32'd0},
      '{OP_TEXT,    8'h62, 1'b0, CHK_AT,    32'd3},
      '{OP_TEXT,    8'h61, 1'b0, CHK_MODEL, 32'd0},
      '{OP_PATTERN, 8'h61, 1'b0, CHK_NONE,  32'd0},
      '{OP_TEXT,    8'h62, 1'b1, CHK_MODEL, 32'd0},
      '{OP_TEXT,    8'h61, 1'b0, CHK_MODEL, 32'd0},
      '{OP_PATTERN, 8'h00, 1'b1, CHK_NONE,  32'd0},
      '{OP_PATTERN, 8'hff, 1'b0, CHK_NONE,  32'd0},
      '{OP_TEXT,    8'h00, 1'b0, CHK_MODEL, 32'd0},
      '{OP_TEXT,    8'hff, 1'b0, CHK_AT,    32'd0},
      '{OP_TEXT,    8'hff, 1'b1, CHK_MODEL, 32'd0},
      '{OP_PATTERN, 8'h61, 1'b1, CHK_NONE,  32'd0},
      '{OP_PATTERN, 8'h61, 1'b0, CHK_NONE,  32'd0},
      '{OP_TEXT,    8'h61, 1'b0, CHK_MODEL, 32'd0},
      '{OP_TEXT,    8'h61, 1'b0, CHK_AT,    32'd0},
      '{OP_TEXT,    8'h61, 1'b0, CHK_AT,    32'd1}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      offer_beat(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].first, dir_rows[i].chk,
                 dir_rows[i].at);

    while (rand_beats < N_RANDOM) begin
      if (rand_beats >= 400) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (rand_beats >= 200) begin
        tx_idle_pct = 66;
        rx_idle_pct = 29;
      end
      // long receiver hold-off while matching text keeps coming
      if (rand_beats >= 400 && !stall_done) begin
        stall_done = 1'b1;
        stall_req = 1'b1;
        base = CH_BITS'($urandom_range(0, 255));
        offer_beat(OP_PATTERN, base, 1'b1, CHK_MODEL, '0);
        repeat (12) offer_beat(OP_TEXT, base, 1'b0, CHK_MODEL, '0);
        rand_beats += 13;
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise
        repeat ($urandom_range(1, 6)) begin
          offer_beat(1'($urandom_range(0, 1)), CH_BITS'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), CHK_MODEL, '0);
          rand_beats++;
        end
      end else begin
        nsym = $urandom_range(1, 3);
        base = CH_BITS'($urandom_range(0, 255));
        for (int s = 0; s < 3; s++) syms[s] = base ^ CH_BITS'(s);
        long_seg = ($urandom_range(0, 11) == 0);
        plen = long_seg ? $urandom_range(56, 70) : $urandom_range(1, 6);
        if (long_seg && $urandom_range(0, 1)) nsym = 1;
        for (int j = 0; j < plen; j++)
          offer_beat(OP_PATTERN, syms[$urandom_range(0, nsym - 1)],
                     (j == 0) && ($urandom_range(0, 9) != 0), CHK_MODEL, '0);
        rand_beats += (plen > PAT_MAX) ? PAT_MAX : plen;
        tlen = plen + $urandom_range(0, long_seg ? 8 : 24);
        for (int j = 0; j < tlen; j++) begin
          if ($urandom_range(0, 19) == 0)
            offer_beat(OP_PATTERN, syms[$urandom_range(0, nsym - 1)], 1'b0, CHK_MODEL, '0);
          else
            offer_beat(OP_TEXT, ($urandom_range(0, 19) == 0) ? CH_BITS'($urandom_range(0, 255))
                                : syms[$urandom_range(0, nsym - 1)],
                       1'($urandom_range(0, 1)), CHK_MODEL, '0);
          rand_beats++;
        end
      end
    end
    push <= 1'b0;

    @(posedge clk);
    while (pending_starts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d beats in and %0d match starts out, %0d pattern beats dropped",
             beats_in, starts_out, dropped);
    $display("longest pattern held %0d, one receiver hold-off of %0d cycles",
             longest, STALL_CYCLES);
    if (err_cnt == 0) begin
      $display("[kmp_pattern_matcher] OK");
    end else begin
      $display("[kmp_pattern_matcher] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kmp_pkg.sv
rtl/kmp_ram.sv
rtl/kmp_queue.sv
rtl/kmp_front.sv
rtl/kmp_engine.sv
rtl/kmp_pattern_matcher.sv
bench/tb_kmp_pattern_matcher.sv
